/* rtl/klwu_pkg.sv */
// ----------------------------------------------------------------------------
// klwu_pkg
// Shared types, codes and constants of the keyed LZ word unpacker.
// ----------------------------------------------------------------------------
package klwu_pkg;

	localparam int HISTORY_DEPTH_DEF = 32768;
	localparam int FIFO_DEPTH        = 4;
	localparam int FIFO_PTR_W        = 2;
	localparam int FIFO_CNT_W        = 3;

	localparam logic [47:0] KEY_RESET  = 48'h4C796CB4A213;
	localparam logic [15:0] HDR_WORD   = 16'h0401;
	localparam logic [2:0]  KEY_LEN    = 3'd6;
	localparam logic [2:0]  KEY_LAST   = 3'd5;

	typedef enum logic [2:0] {
		PH_HDR_LO  = 3'd0,
		PH_HDR_HI  = 3'd1,
		PH_WORD_LO = 3'd2,
		PH_WORD_HI = 3'd3,
		PH_DIST_LO = 3'd4,
		PH_DIST_HI = 3'd5,
		PH_LITERAL = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		DONE_RUNNING    = 2'd0,
		DONE_ENDED      = 2'd1,
		DONE_BAD_HEADER = 2'd2
	} done_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_ENDED    = 3'd1,
		ST_BAD_HDR  = 3'd2,
		ST_BAD_DIST = 3'd3,
		ST_REFUSED  = 3'd4
	} status_t;

	typedef struct packed {
		logic       out_valid;
		logic [7:0] out_byte;
		logic       copy_pending;
		status_t    status;
	} rsp_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic wr_copy;
	} hist_ctl_t;

	function automatic status_t done_status(input done_t d);
		status_t s;
		case (d)
			DONE_RUNNING:    s = ST_OK;
			DONE_ENDED:      s = ST_ENDED;
			DONE_BAD_HEADER: s = ST_BAD_HDR;
			default:         s = ST_OK;
		endcase
		return s;
	endfunction

endpackage

/* rtl/klwu_if.sv */
// ----------------------------------------------------------------------------
// klwu channel interfaces
// Valid/ready channels for request items, result items and key writes.
// ----------------------------------------------------------------------------
interface klwu_req_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] data_byte;
	logic       first_byte;

	modport source (output valid, cmd, data_byte, first_byte, input ready);
	modport sink   (input valid, cmd, data_byte, first_byte, output ready);
endinterface

interface klwu_rsp_if;
	logic       valid;
	logic       ready;
	logic       out_valid;
	logic [7:0] out_byte;
	logic       copy_pending;
	logic [2:0] status;

	modport source (output valid, out_valid, out_byte, copy_pending, status, input ready);
	modport sink   (input valid, out_valid, out_byte, copy_pending, status, output ready);
endinterface

interface klwu_cfg_if;
	logic        valid;
	logic        ready;
	logic [47:0] key_bytes;

	modport source (output valid, key_bytes, input ready);
	modport sink   (input valid, key_bytes, output ready);
endinterface

/* rtl/keyed_lz_word_unpacker.sv */
// ----------------------------------------------------------------------------
// keyed_lz_word_unpacker
// Header check, key removal, word parsing and back-reference copy from a
// byte history.
//
//   channel  dir  payload                                   handshake
//   req      in   cmd, data_byte, first_byte                valid/ready
//   rsp      out  out_valid, out_byte, copy_pending, status valid/ready
//   cfg      in   key_bytes                                 valid/ready
//
// One item per cycle while req.ready is high; its result item is registered in
// stage 1, then buffered. Copy bytes are read from the history memory in the
// cycle after accept, with the previous item's write forwarded for distance
// one. req.ready drops only when the four-entry result buffer plus the item
// in flight would overflow. Reset clears all bookkeeping, not the history.
// ----------------------------------------------------------------------------
module keyed_lz_word_unpacker #(
	parameter int HISTORY_DEPTH = klwu_pkg::HISTORY_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	klwu_req_if.sink   req,
	klwu_rsp_if.source rsp,
	klwu_cfg_if.sink   cfg
);
	import klwu_pkg::*;

	localparam int AW = $clog2(HISTORY_DEPTH);
	localparam int BW = $clog2(HISTORY_DEPTH + 1);

	// architectural state
	logic [47:0]   key_q;
	phase_t        phase_q,        n_phase;
	logic [2:0]    key_pos_q,      n_key_pos;
	logic [7:0]    held_q,         n_held;
	logic [14:0]   pending_q,      n_pending;
	logic [15:0]   lit_left_q,     n_lit_left;
	logic [14:0]   copy_dist_q,    n_copy_dist;
	logic [15:0]   copy_left_q,    n_copy_left;
	logic [AW-1:0] wp_q,           n_wp;
	logic [BW-1:0] bw_q,           n_bw;
	done_t         done_q,         n_done;

	// pipeline stage 1
	logic          valid_s1;
	logic          out_valid_s1;
	logic          copy_s1;
	logic [7:0]    lit_s1;
	logic [AW-1:0] waddr_s1;
	logic          pending_s1;
	status_t       status_s1;

	// stage 0 decode
	logic          accept;
	logic          restart;
	logic          do_copy;
	logic          refuse;
	logic          stopped;
	logic          do_parse;
	phase_t        b_phase;
	logic [2:0]    b_key_pos;
	logic [7:0]    b_held;
	logic [14:0]   b_pending;
	logic [15:0]   b_lit_left;
	logic [15:0]   b_copy_left;
	logic [AW-1:0] b_wp;
	logic [BW-1:0] b_bw;
	logic [AW-1:0] wp_inc;
	logic [BW-1:0] bw_inc;
	logic [2:0]    kidx;
	logic [7:0]    kbyte;
	logic [7:0]    dec;
	logic [15:0]   word;
	logic [15:0]   hdr;
	logic          dist_bad;
	logic [15:0]   lit_dec;
	logic [15:0]   d16;
	logic [15:0]   w16;
	logic [15:0]   raddr16;
	logic [AW-1:0] rd_addr;

	// stage 0 results
	logic          r_valid;
	logic [7:0]    r_lit;
	status_t       r_status;

	logic [FIFO_CNT_W-1:0] fifo_count;
	logic [FIFO_CNT_W:0]   fill;
	hist_ctl_t             hctl;
	logic [7:0]            byte_s1;
	rsp_t                  push_data;

	assign fill      = {1'b0, fifo_count} + (FIFO_CNT_W+1)'(valid_s1);
	assign req.ready = (fill < (FIFO_CNT_W+1)'(FIFO_DEPTH));
	assign accept    = req.valid & req.ready;
	assign cfg.ready = 1'b1;

	// command decode
	assign restart  = !req.cmd & req.first_byte;
	assign do_copy  = req.cmd & (copy_left_q != '0);
	assign refuse   = !req.cmd & !req.first_byte & (copy_left_q != '0);
	assign stopped  = !req.cmd & !req.first_byte & (copy_left_q == '0)
		& (done_q != DONE_RUNNING);
	assign do_parse = !req.cmd & !refuse & !stopped;

	// bookkeeping as seen after an optional restart
	assign b_phase     = restart ? PH_HDR_LO : phase_q;
	assign b_key_pos   = restart ? '0 : key_pos_q;
	assign b_held      = restart ? '0 : held_q;
	assign b_pending   = restart ? '0 : pending_q;
	assign b_lit_left  = restart ? '0 : lit_left_q;
	assign b_copy_left = restart ? '0 : copy_left_q;
	assign b_wp        = restart ? '0 : wp_q;
	assign b_bw        = restart ? '0 : bw_q;

	assign wp_inc = (({1'b0, b_wp} + (AW+1)'(1)) >= (AW+1)'(HISTORY_DEPTH))
		? '0 : b_wp + AW'(1);
	assign bw_inc = (b_bw < BW'(HISTORY_DEPTH)) ? b_bw + BW'(1) : b_bw;

	// key removal
	assign kidx     = (b_key_pos < KEY_LEN) ? b_key_pos : '0;
	assign kbyte    = key_q[{kidx, 3'b000} +: 8];
	assign dec      = req.data_byte - kbyte;
	assign word     = {dec, b_held};
	assign hdr      = {req.data_byte, b_held};
	assign dist_bad = (word == '0) || word[15] || (word > 16'(b_bw));
	assign lit_dec  = (b_lit_left != '0) ? b_lit_left - 16'd1 : b_lit_left;

	// copy source address
	assign d16     = 16'(copy_dist_q);
	assign w16     = 16'(wp_q);
	assign raddr16 = (w16 >= d16) ? (w16 - d16) : (w16 + 16'(HISTORY_DEPTH) - d16);
	assign rd_addr = raddr16[AW-1:0];

	// next state
	always_comb begin
		n_phase     = phase_q;
		n_key_pos   = key_pos_q;
		n_held      = held_q;
		n_pending   = pending_q;
		n_lit_left  = lit_left_q;
		n_copy_dist = copy_dist_q;
		n_copy_left = copy_left_q;
		n_wp        = wp_q;
		n_bw        = bw_q;
		n_done      = done_q;
		if (do_copy) begin
			n_wp        = wp_inc;
			n_bw        = bw_inc;
			n_copy_left = copy_left_q - 16'd1;
		end else if (do_parse) begin
			n_phase     = b_phase;
			n_key_pos   = b_key_pos;
			n_held      = b_held;
			n_pending   = b_pending;
			n_lit_left  = b_lit_left;
			n_copy_left = b_copy_left;
			n_wp        = b_wp;
			n_bw        = b_bw;
			if (restart) begin
				n_copy_dist = '0;
				n_done      = DONE_RUNNING;
			end
			case (b_phase)
				PH_HDR_LO: begin
					n_held  = req.data_byte;
					n_phase = PH_HDR_HI;
				end
				PH_HDR_HI: begin
					if (hdr != HDR_WORD) begin
						n_done = DONE_BAD_HEADER;
					end else begin
						n_phase   = PH_WORD_LO;
						n_key_pos = '0;
					end
				end
				default: begin
					n_key_pos = (kidx == KEY_LAST) ? '0 : kidx + 3'd1;
					case (b_phase)
						PH_WORD_LO: begin
							n_held  = dec;
							n_phase = PH_WORD_HI;
						end
						PH_DIST_LO: begin
							n_held  = dec;
							n_phase = PH_DIST_HI;
						end
						PH_WORD_HI: begin
							if (word == '0) begin
								n_done = DONE_ENDED;
							end else if (word[15]) begin
								n_pending = word[14:0];
								n_phase   = PH_DIST_LO;
							end else begin
								n_lit_left = {word[14:0], 1'b0};
								n_phase    = PH_LITERAL;
							end
						end
						PH_DIST_HI: begin
							if (!dist_bad) begin
								n_copy_dist = word[14:0];
								n_copy_left = {b_pending, 1'b0};
							end
							n_pending = '0;
							n_phase   = PH_WORD_LO;
						end
						PH_LITERAL: begin
							n_wp       = wp_inc;
							n_bw       = bw_inc;
							n_lit_left = lit_dec;
							if (lit_dec == '0) begin
								n_phase = PH_WORD_LO;
							end
						end
						default: begin
							n_phase = b_phase;
						end
					endcase
				end
			endcase
		end
	end

	// stage 0 outputs
	always_comb begin
		r_valid  = 1'b0;
		r_lit    = '0;
		r_status = ST_OK;
		if (req.cmd) begin
			r_valid  = do_copy;
			r_status = done_status(done_q);
		end else if (refuse) begin
			r_status = ST_REFUSED;
		end else if (stopped) begin
			r_status = done_status(done_q);
		end else begin
			case (b_phase)
				PH_HDR_HI: begin
					if (hdr != HDR_WORD) begin
						r_status = ST_BAD_HDR;
					end
				end
				PH_WORD_HI: begin
					if (word == '0) begin
						r_status = ST_ENDED;
					end
				end
				PH_DIST_HI: begin
					if (dist_bad) begin
						r_status = ST_BAD_DIST;
					end
				end
				PH_LITERAL: begin
					r_valid = 1'b1;
					r_lit   = dec;
				end
				default: begin
					r_status = ST_OK;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q       <= KEY_RESET;
			phase_q     <= PH_HDR_LO;
			key_pos_q   <= '0;
			held_q      <= '0;
			pending_q   <= '0;
			lit_left_q  <= '0;
			copy_dist_q <= '0;
			copy_left_q <= '0;
			wp_q        <= '0;
			bw_q        <= '0;
			done_q      <= DONE_RUNNING;
			valid_s1    <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				key_q <= cfg.key_bytes;
			end
			if (accept) begin
				phase_q     <= n_phase;
				key_pos_q   <= n_key_pos;
				held_q      <= n_held;
				pending_q   <= n_pending;
				lit_left_q  <= n_lit_left;
				copy_dist_q <= n_copy_dist;
				copy_left_q <= n_copy_left;
				wp_q        <= n_wp;
				bw_q        <= n_bw;
				done_q      <= n_done;
			end
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_valid_s1 <= r_valid;
			copy_s1      <= do_copy;
			lit_s1       <= r_lit;
			waddr_s1     <= b_wp;
			pending_s1   <= (n_copy_left != '0);
			status_s1    <= r_status;
		end
	end

	assign hctl.rd_en   = accept & do_copy;
	assign hctl.wr_en   = valid_s1 & out_valid_s1;
	assign hctl.wr_copy = valid_s1 & copy_s1;

	klwu_history #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_history (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (hctl),
		.rd_addr (rd_addr),
		.wr_addr (waddr_s1),
		.wr_lit  (lit_s1),
		.byte_s1 (byte_s1)
	);

	assign push_data.out_valid    = out_valid_s1;
	assign push_data.out_byte     = byte_s1;
	assign push_data.copy_pending = pending_s1;
	assign push_data.status       = status_s1;

	klwu_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s1),
		.push_data (push_data),
		.count     (fifo_count),
		.rsp       (rsp)
	);

endmodule

/* rtl/klwu_history.sv */
// ----------------------------------------------------------------------------
// klwu_history
// Output history memory with registered read and write-to-read forwarding.
// ----------------------------------------------------------------------------
module klwu_history #(
	parameter int HISTORY_DEPTH = klwu_pkg::HISTORY_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  klwu_pkg::hist_ctl_t              ctl,
	input  logic [$clog2(HISTORY_DEPTH)-1:0] rd_addr,
	input  logic [$clog2(HISTORY_DEPTH)-1:0] wr_addr,
	input  logic [7:0]                       wr_lit,
	output logic [7:0]                       byte_s1
);
	import klwu_pkg::*;

	logic [7:0] mem [HISTORY_DEPTH];
	logic [7:0] rdata_q;
	logic [7:0] fwd_data_q;
	logic       fwd_hit_q;

	// copy byte comes from memory unless the previous item wrote that entry
	assign byte_s1 = ctl.wr_copy ? (fwd_hit_q ? fwd_data_q : rdata_q) : wr_lit;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= byte_s1;
		end
		if (ctl.rd_en) begin
			rdata_q    <= mem[rd_addr];
			fwd_data_q <= byte_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_hit_q <= 1'b0;
		end else if (ctl.rd_en) begin
			fwd_hit_q <= ctl.wr_en && (wr_addr == rd_addr);
		end
	end

endmodule

/* rtl/klwu_out_fifo.sv */
// ----------------------------------------------------------------------------
// klwu_out_fifo
// Small result buffer between the pipeline and the result channel.
// ----------------------------------------------------------------------------
module klwu_out_fifo (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	input  klwu_pkg::rsp_t                       push_data,
	output logic [klwu_pkg::FIFO_CNT_W-1:0]      count,
	klwu_rsp_if.source                           rsp
);
	import klwu_pkg::*;

	rsp_t                  ent_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic                  pop;
	rsp_t                  head;

	assign head             = ent_q[rd_ptr_q];
	assign rsp.valid        = (count_q != '0);
	assign rsp.out_valid    = head.out_valid;
	assign rsp.out_byte     = head.out_byte;
	assign rsp.copy_pending = head.copy_pending;
	assign rsp.status       = head.status;
	assign pop              = rsp.valid & rsp.ready;
	assign count            = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			count_q <= count_q + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
		end
	end

endmodule

/* verif/keyed_lz_word_unpacker_tb.sv */
// ----------------------------------------------------------------------------
// keyed_lz_word_unpacker_tb
// Drives whole packed files (header, keyed literal and back-reference words,
// copy pulls) plus broken files and noise, predicts every result item
// in-bench and checks each one field by field under several key settings and
// sender/receiver idle patterns.
// ----------------------------------------------------------------------------
module keyed_lz_word_unpacker_tb;
	import klwu_pkg::*;

	localparam int   HIST_DEPTH      = HISTORY_DEPTH_DEF;
	localparam logic CMD_FEED        = 1'b0;
	localparam logic CMD_PULL        = 1'b1;
	localparam int   IDLE_NONE       = 0;
	localparam int   IDLE_SRC        = 1;
	localparam int   IDLE_SINK       = 2;
	localparam int   IDLE_BOTH       = 3;
	localparam int   ITEMS_PER_PHASE = 200;
	localparam int   RUN_LIMIT       = 2000000;

	typedef struct packed {
		logic       cmd;
		logic [7:0] data_byte;
		logic       first_byte;
	} unpack_req_t;

	logic clk;
	logic arst_n;

	klwu_req_if req_ch ();
	klwu_rsp_if rsp_ch ();
	klwu_cfg_if cfg_ch ();

	keyed_lz_word_unpacker DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	unpack_req_t unpack_requests[$];
	rsp_t        predicted_results[$];
	rsp_t        drv_res;
	rsp_t        want;
	int          error_count = 0;
	int          idle_mode   = IDLE_NONE;

	// unpacker state as predicted
	logic [47:0] active_key;
	phase_t      parse_ph;
	logic [2:0]  key_idx;
	logic [7:0]  low_hold;
	logic [14:0] copy_words;
	logic [15:0] lit_remaining;
	logic [14:0] back_dist;
	logic [15:0] copy_remaining;
	logic [7:0]  hist_mem [HIST_DEPTH];
	logic [14:0] hist_wr;
	logic [15:0] hist_fill;
	done_t       stop_state;

	// file builder state
	logic [47:0] gen_key;
	int          gen_kpos;
	int          gen_written;
	int          phase_items;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#RUN_LIMIT;
		$display("keyed_lz_word_unpacker_tb: errors");
		$finish;
	end

	function automatic bit roll(input int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	function automatic int src_pct();
		return (idle_mode == IDLE_SRC) ? 80 : (idle_mode == IDLE_BOTH) ? 14 : 0;
	endfunction

	function automatic int sink_pct();
		return (idle_mode == IDLE_SINK) ? 80 : (idle_mode == IDLE_BOTH) ? 14 : 0;
	endfunction

	task automatic restart_stream();
		parse_ph       = PH_HDR_LO;
		key_idx        = '0;
		low_hold       = '0;
		copy_words     = '0;
		lit_remaining  = '0;
		back_dist      = '0;
		copy_remaining = '0;
		hist_wr        = '0;
		hist_fill      = '0;
		stop_state     = DONE_RUNNING;
	endtask

	task automatic history_push(input logic [7:0] b);
		hist_mem[hist_wr] = b;
		hist_wr = hist_wr + 15'd1;
		if (hist_fill < HIST_DEPTH)
			hist_fill = hist_fill + 16'd1;
	endtask

	function automatic status_t stop_code();
		case (stop_state)
			DONE_ENDED:      return ST_ENDED;
			DONE_BAD_HEADER: return ST_BAD_HDR;
			default:         return ST_OK;
		endcase
	endfunction

	task automatic predict_unpack(input unpack_req_t it, output rsp_t res);
		logic [2:0]  k;
		logic [7:0]  plain;
		logic [15:0] w;
		res = '0;
		res.status = ST_OK;
		if (it.cmd == CMD_PULL) begin
			if (copy_remaining != 0) begin
				plain = hist_mem[hist_wr - back_dist];
				history_push(plain);
				copy_remaining = copy_remaining - 16'd1;
				res.out_valid = 1'b1;
				res.out_byte  = plain;
			end
			res.status = stop_code();
		end else if (!it.first_byte && copy_remaining != 0) begin
			res.status = ST_REFUSED;
		end else if (!it.first_byte && stop_state != DONE_RUNNING) begin
			res.status = stop_code();
		end else begin
			if (it.first_byte)
				restart_stream();
			case (parse_ph)
				PH_HDR_LO: begin
					low_hold = it.data_byte;
					parse_ph = PH_HDR_HI;
				end
				PH_HDR_HI: begin
					if ({it.data_byte, low_hold} != HDR_WORD) begin
						stop_state = DONE_BAD_HEADER;
						res.status = ST_BAD_HDR;
					end else begin
						parse_ph = PH_WORD_LO;
						key_idx  = '0;
					end
				end
				default: begin
					k = (key_idx < KEY_LEN) ? key_idx : 3'd0;
					plain = it.data_byte - active_key[8*k +: 8];
					key_idx = (k == KEY_LAST) ? 3'd0 : k + 3'd1;
					case (parse_ph)
						PH_WORD_LO, PH_DIST_LO: begin
							low_hold = plain;
							parse_ph = phase_t'(parse_ph + 3'd1);
						end
						PH_WORD_HI: begin
							w = {plain, low_hold};
							if (w == 16'd0) begin
								stop_state = DONE_ENDED;
								res.status = ST_ENDED;
							end else if (w[15]) begin
								copy_words = w[14:0];
								parse_ph   = PH_DIST_LO;
							end else begin
								lit_remaining = {w[14:0], 1'b0};
								parse_ph      = PH_LITERAL;
							end
						end
						PH_DIST_HI: begin
							w = {plain, low_hold};
							if (w == 16'd0 || w[15] || w > hist_fill) begin
								res.status = ST_BAD_DIST;
							end else begin
								back_dist      = w[14:0];
								copy_remaining = {copy_words, 1'b0};
							end
							copy_words = '0;
							parse_ph   = PH_WORD_LO;
						end
						default: begin
							history_push(plain);
							res.out_valid = 1'b1;
							res.out_byte  = plain;
							if (lit_remaining > 0)
								lit_remaining = lit_remaining - 16'd1;
							if (lit_remaining == 0)
								parse_ph = PH_WORD_LO;
						end
					endcase
				end
			endcase
		end
		res.copy_pending = (copy_remaining != 0);
	endtask

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			req_ch.valid      <= 1'b0;
			req_ch.cmd        <= CMD_FEED;
			req_ch.data_byte  <= 8'h00;
			req_ch.first_byte <= 1'b0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				predict_unpack(unpack_requests[0], drv_res);
				predicted_results.push_back(drv_res);
				unpack_requests.delete(0);
			end
			if (!(req_ch.valid && !req_ch.ready)) begin
				if (unpack_requests.size() != 0 && !roll(src_pct())) begin
					req_ch.valid      <= 1'b1;
					req_ch.cmd        <= unpack_requests[0].cmd;
					req_ch.data_byte  <= unpack_requests[0].data_byte;
					req_ch.first_byte <= unpack_requests[0].first_byte;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (predicted_results.size() == 0) begin
					$error("result item with nothing predicted");
					error_count++;
				end else begin
					want = predicted_results[0];
					predicted_results.delete(0);
					if (rsp_ch.out_valid !== want.out_valid) begin
						$error("out_valid: expected %0d, got %0d", want.out_valid, rsp_ch.out_valid);
						error_count++;
					end
					if (rsp_ch.out_byte !== want.out_byte) begin
						$error("out_byte: expected %0h, got %0h", want.out_byte, rsp_ch.out_byte);
						error_count++;
					end
					if (rsp_ch.copy_pending !== want.copy_pending) begin
						$error("copy_pending: expected %0d, got %0d", want.copy_pending,
							rsp_ch.copy_pending);
						error_count++;
					end
					if (rsp_ch.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp_ch.status);
						error_count++;
					end
				end
			end
			rsp_ch.ready <= !roll(sink_pct());
		end
	end

	task automatic push_raw(input logic cmd, input logic [7:0] b, input logic first);
		unpack_req_t it;
		it.cmd        = cmd;
		it.data_byte  = b;
		it.first_byte = first;
		unpack_requests.push_back(it);
		phase_items++;
	endtask

	task automatic feed_coded(input logic [7:0] plain);
		push_raw(CMD_FEED, plain + gen_key[8*gen_kpos +: 8], 1'b0);
		gen_kpos = (gen_kpos == 5) ? 0 : gen_kpos + 1;
	endtask

	task automatic feed_word(input logic [15:0] w);
		feed_coded(w[7:0]);
		feed_coded(w[15:8]);
	endtask

	task automatic start_file();
		push_raw(CMD_FEED, HDR_WORD[7:0], 1'b1);
		push_raw(CMD_FEED, HDR_WORD[15:8], 1'b0);
		gen_kpos    = 0;
		gen_written = 0;
	endtask

	task automatic copy_pulls(input int n);
		int i;
		for (i = 0; i < n; i++) begin
			if (roll(4))
				push_raw(CMD_FEED, 8'($urandom_range(0, 255)), 1'b0);
			push_raw(CMD_PULL, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		end
	endtask

	task automatic gen_file(input int segs);
		int s;
		int sel;
		int c;
		int d;
		int n;
		start_file();
		for (s = 0; s < segs; s++) begin
			sel = $urandom_range(0, 99);
			if (sel >= 45 && sel < 80 && gen_written == 0)
				sel = 0;
			if (sel < 45) begin
				n = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 4);
				feed_word(16'(n));
				repeat (2 * n) feed_coded(8'($urandom_range(0, 255)));
				gen_written += 2 * n;
			end else if (sel < 80) begin
				c = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
				case ($urandom_range(0, 3))
					0:       d = 1;
					1:       d = (gen_written >= 2) ? 2 : 1;
					2:       d = gen_written;
					default: d = $urandom_range(1, gen_written);
				endcase
				feed_word(16'h8000 | 16'(c));
				feed_word(16'(d));
				copy_pulls(2 * c);
				gen_written += 2 * c;
			end else if (sel < 88) begin
				case ($urandom_range(0, 2))
					0:       d = 0;
					1:       d = gen_written + $urandom_range(1, 20);
					default: d = 32'h8000 | $urandom_range(0, 32767);
				endcase
				feed_word(16'h8000 | 16'($urandom_range(1, 3)));
				feed_word(16'(d));
			end else if (sel < 94) begin
				push_raw(CMD_PULL, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end else if (gen_written > 0) begin
				// leave the copy unfinished, the next file restarts over it
				c = $urandom_range(1, 6);
				feed_word(16'h8000 | 16'(c));
				feed_word(16'($urandom_range(1, gen_written)));
				copy_pulls($urandom_range(0, 2 * c - 1));
				return;
			end
		end
		if (roll(60)) begin
			feed_word(16'h0000);
			repeat ($urandom_range(0, 2))
				push_raw(CMD_FEED, 8'($urandom_range(0, 255)), 1'b0);
			if (roll(50))
				push_raw(CMD_PULL, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		end
	endtask

	task automatic bad_header_file();
		push_raw(CMD_FEED, 8'($urandom_range(0, 255)), 1'b1);
		push_raw(CMD_FEED, 8'($urandom_range(0, 255)), 1'b0);
		repeat ($urandom_range(1, 4))
			push_raw(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0);
	endtask

	task automatic random_phase(input int n);
		int sel;
		phase_items = 0;
		while (phase_items < n) begin
			sel = $urandom_range(0, 99);
			if (sel < 78)
				gen_file($urandom_range(2, 8));
			else if (sel < 88)
				bad_header_file();
			else
				repeat ($urandom_range(4, 12))
					push_raw(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
						$urandom_range(0, 9) == 0);
		end
	endtask

	task automatic drain();
		while (unpack_requests.size() != 0 || req_ch.valid || predicted_results.size() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_key(input logic [47:0] k);
		@(posedge clk);
		cfg_ch.valid     <= 1'b1;
		cfg_ch.key_bytes <= k;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
		active_key = k;
		gen_key    = k;
		@(negedge clk);
	endtask

	initial begin
		logic [63:0] rnd;
		int          p;
		arst_n            = 1'b0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.key_bytes  = KEY_RESET;
		active_key        = KEY_RESET;
		gen_key           = KEY_RESET;
		restart_stream();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: literals, copy with refused byte, zero count, bad distance,
		// restart over a pending copy into a bad header, stopped stream
		start_file();
		feed_word(16'h0001);
		feed_coded(8'h00);
		feed_coded(8'hFF);
		feed_word(16'h8001);
		feed_word(16'h0001);
		push_raw(CMD_FEED, 8'h00, 1'b0);
		push_raw(CMD_PULL, 8'hFF, 1'b1);
		push_raw(CMD_PULL, 8'h00, 1'b0);
		feed_word(16'h8000);
		feed_word(16'h0003);
		feed_word(16'h8001);
		feed_word(16'h0000);
		feed_word(16'h8001);
		feed_word(16'h0002);
		push_raw(CMD_FEED, 8'h01, 1'b1);
		push_raw(CMD_FEED, 8'h05, 1'b0);
		push_raw(CMD_FEED, 8'hFF, 1'b0);
		push_raw(CMD_PULL, 8'h00, 1'b0);
		drain();

		random_phase(ITEMS_PER_PHASE);
		drain();

		for (p = 1; p <= 4; p++) begin
			rnd = {$urandom, $urandom};
			case (p)
				1: begin
					idle_mode = IDLE_SRC;
					write_key(48'h0);
				end
				2: begin
					idle_mode = IDLE_SINK;
					write_key(48'hFFFF_FFFF_FFFF);
				end
				3: begin
					idle_mode = IDLE_BOTH;
					write_key(rnd[47:0]);
				end
				default: begin
					idle_mode = IDLE_NONE;
					write_key(rnd[47:0]);
				end
			endcase
			random_phase(ITEMS_PER_PHASE);
			drain();
		end

		if (error_count == 0) begin
			$display("keyed_lz_word_unpacker_tb: clean");
		end else begin
			$display("keyed_lz_word_unpacker_tb: errors");
		end
		$finish;
	end

endmodule
